// File: sv/deq_pkg.sv
// types and codes shared by the double-ended queue modules
`default_nettype none
package deq_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [STAT_W-1:0]        status_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_PEEK_FRONT = 3'd4;
   localparam cmd_type CMD_PEEK_BACK  = 3'd5;
   localparam cmd_type CMD_LIST_FRONT = 3'd6;
   localparam cmd_type CMD_LIST_BACK  = 3'd7;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: sv/deq_ram.sv
// entry storage: one write port, one registered read port
`default_nettype none
module deq_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire deq_pkg::data_type  wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output deq_pkg::data_type       rd_data
);
   import deq_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/deq_seq.sv
// command sequencer with the shared ring index adder
`default_nettype none
module deq_seq #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4,
   parameter int CNT_W = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire deq_pkg::cmd_type    req_command,
   input  wire deq_pkg::data_type   req_push_value,
   output logic                     rsp_valid,
   output deq_pkg::data_type        rsp_item_value,
   output deq_pkg::status_type      rsp_status,
   output logic                     rsp_last_of_run,
   output logic                     mem_wr_en,
   output logic [PTR_W-1:0]         mem_wr_addr,
   output deq_pkg::data_type        mem_wr_data,
   output logic                     mem_rd_en,
   output logic [PTR_W-1:0]         mem_rd_addr,
   input  wire deq_pkg::data_type   mem_rd_data
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LIST = 2'd2;

   localparam logic [PTR_W:0] DEPTH_W = (PTR_W+1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [1:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   data_type          val_ff, val_in;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  off_full;
   logic [PTR_W:0]    ring_sum;
   logic [PTR_W-1:0]  ring_addr;
   logic              is_empty, is_full, list_last;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == DEPTH_C);
   assign list_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff) ||
                      (cmd_ff == CMD_PEEK_FRONT) || (cmd_ff == CMD_PEEK_BACK);

   // offset into the ring, picked per step
   always_comb begin
      off_full = '0;
      if (state_ff == ST_LIST) begin
         if (cmd_ff == CMD_LIST_FRONT) begin
            off_full = CNT_W'(idx_ff) + CNT_W'(1);
         end else begin
            off_full = count_ff - CNT_W'(idx_ff) - CNT_W'(2);
         end
      end else begin
         case (cmd_ff)
            CMD_PUSH_FRONT:                 off_full = CNT_W'(DEPTH - 1);
            CMD_PUSH_BACK:                  off_full = count_ff;
            CMD_POP_FRONT:                  off_full = CNT_W'(1);
            CMD_PEEK_BACK, CMD_LIST_BACK:   off_full = count_ff - CNT_W'(1);
            default:                        off_full = '0;
         endcase
      end
   end

   // shared adder: (front + offset) wrapped at the depth
   assign ring_sum  = {1'b0, front_ff} + {1'b0, off_full[PTR_W-1:0]};
   assign ring_addr = (ring_sum >= DEPTH_W) ? PTR_W'(ring_sum - DEPTH_W)
                                            : ring_sum[PTR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               val_in   = req_push_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = STAT_OK;
            rsp_last_in   = 1'b1;
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (is_full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     if (cmd_ff == CMD_PUSH_FRONT) begin
                        front_in = ring_addr;
                     end
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  if (is_empty) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        front_in = '0;
                     end else if (cmd_ff == CMD_POP_FRONT) begin
                        front_in = ring_addr;
                     end
                  end
               end
               default: begin
                  if (is_empty) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     // read issued now, data shows up in the list step
                     rsp_valid_in = 1'b0;
                     mem_rd_en    = 1'b1;
                     idx_in       = '0;
                     state_in     = ST_LIST;
                  end
               end
            endcase
         end
         ST_LIST: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = mem_rd_data;
            rsp_status_in = STAT_OK;
            rsp_last_in   = list_last;
            if (list_last) begin
               state_in = ST_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               idx_in    = idx_ff + PTR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign mem_wr_addr     = ring_addr;
   assign mem_wr_data     = val_ff;
   assign mem_rd_addr     = ring_addr;

endmodule
`default_nettype wire

// File: sv/double_ended_queue.sv
// double-ended queue of signed 32-bit values held in a ring of DEPTH entries
//
// a request is taken at a rising edge where start is high and busy is low;
// req_command picks push front/back, pop front/back, peek front/back or a
// listing front-first/back-first, and req_push_value is stored by pushes.
// each result shows on the rsp_ ports for one cycle with rsp_valid high;
// rsp_last_of_run marks the final result of a request. results cannot be
// held off, so nothing stalls on the result side.
// push and pop: busy only in the exec state, and the result is registered
// from it. peek: the exec state issues the read and the list state returns
// the entry. a listing of n entries: reads as for peek, then one result per
// cycle, n in all. empty queues and full pushes answer like push.
// the rate is set by the sequencer stepping through the ring with a single
// wrap-around index adder and the registered read port of the entry memory.
// reset empties the queue and puts the front at entry 0; the entry memory
// itself is not cleared, and only written entries are ever read.
`default_nettype none
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire deq_pkg::cmd_type    req_command,
   input  wire deq_pkg::data_type   req_push_value,
   output logic                     rsp_valid,
   output deq_pkg::data_type        rsp_item_value,
   output deq_pkg::status_type      rsp_status,
   output logic                     rsp_last_of_run
);
   import deq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              mem_wr_en;
   logic [PTR_W-1:0]  mem_wr_addr;
   data_type          mem_wr_data;
   logic              mem_rd_en;
   logic [PTR_W-1:0]  mem_rd_addr;
   data_type          mem_rd_data;

   deq_seq #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_item_value  (rsp_item_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   deq_ram #(
      .DEPTH (DEPTH),
      .AW    (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the double-ended queue
`timescale 1ns / 1ps
module tb_top;
   import deq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 400;

   typedef struct {
      data_type   item_value;
      status_type status;
      logic       last_of_run;
   } deq_result_type;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_mode_type;

   // ring model of the queue plus the results still owed by the block
   class deq_scoreboard;
      data_type       entries[DEPTH];
      int             front_pos;
      int             count;
      deq_result_type awaited[$];
      int             failures;
      int             requests;
      int             checked;
      int             full_pushes;
      int             empty_answers;
      int             listed_entries;

      function new();
         front_pos      = 0;
         count          = 0;
         failures       = 0;
         requests       = 0;
         checked        = 0;
         full_pushes    = 0;
         empty_answers  = 0;
         listed_entries = 0;
      endfunction

      function void owe(data_type value, status_type status, logic last);
         deq_result_type r;
         r.item_value  = value;
         r.status      = status;
         r.last_of_run = last;
         awaited.push_back(r);
      endfunction

      function void note_request(cmd_type cmd, data_type value);
         int off;
         requests++;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  full_pushes++;
                  owe('0, STAT_FULL, 1'b1);
               end else begin
                  if (cmd == CMD_PUSH_FRONT) begin
                     front_pos = (front_pos + DEPTH - 1) % DEPTH;
                     entries[front_pos] = value;
                  end else begin
                     entries[(front_pos + count) % DEPTH] = value;
                  end
                  count++;
                  owe('0, STAT_OK, 1'b1);
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (count == 0) begin
                  empty_answers++;
                  owe('0, STAT_EMPTY, 1'b1);
               end else begin
                  if (cmd == CMD_POP_FRONT) front_pos = (front_pos + 1) % DEPTH;
                  count--;
                  // an emptied queue restarts at entry 0
                  if (count == 0) front_pos = 0;
                  owe('0, STAT_OK, 1'b1);
               end
            end
            CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
               if (count == 0) begin
                  empty_answers++;
                  owe('0, STAT_EMPTY, 1'b1);
               end else begin
                  off = (cmd == CMD_PEEK_FRONT) ? 0 : count - 1;
                  owe(entries[(front_pos + off) % DEPTH], STAT_OK, 1'b1);
               end
            end
            default: begin
               if (count == 0) begin
                  empty_answers++;
                  owe('0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++) begin
                     off = (cmd == CMD_LIST_FRONT) ? i : count - 1 - i;
                     owe(entries[(front_pos + off) % DEPTH], STAT_OK, i + 1 == count);
                  end
                  listed_entries += count;
               end
            end
         endcase
      endfunction

      function void check_result(data_type value, status_type status, logic last);
         deq_result_type e;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: item_value %0d status %0d last %0b",
                   value, status, last);
            failures++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (value !== e.item_value) begin
            $error("item_value mismatch: expected %0d, actual %0d", e.item_value, value);
            failures++;
         end
         if (status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            failures++;
         end
         if (last !== e.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", e.last_of_run, last);
            failures++;
         end
      endfunction

      function void check_drained();
         if (awaited.size() != 0) begin
            $error("%0d results never arrived", awaited.size());
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   cmd_type    req_command = CMD_PUSH_FRONT;
   data_type   req_push_value = '0;
   logic       rsp_valid;
   data_type   rsp_item_value;
   status_type rsp_status;
   logic       rsp_last_of_run;

   deq_scoreboard book;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_item_value  (rsp_item_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         book.check_result(rsp_item_value, rsp_status, rsp_last_of_run);
   end

   // called just after a rising edge; returns once the request is taken
   task automatic send_request(input cmd_type cmd, input data_type value);
      req_command    <= cmd;
      req_push_value <= value;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      book.note_request(cmd, value);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic data_type random_value();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type random_command(phase_mode_type mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         PH_GROW:
            if (r < 75) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         PH_SHRINK:
            if (r < 65) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         default: ;
      endcase
      return cmd_type'($urandom_range(7));
   endfunction

   cmd_type        directed_cmds[$];
   data_type       directed_vals[$];
   phase_mode_type mode;
   int             issued;
   int             phase_len;
   int             burst_left;
   int             wait_cycles;

   initial begin
      book = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue answers, then extremes through both ends
      directed_cmds = '{CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK,
                        CMD_LIST_FRONT, CMD_LIST_BACK,
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_PUSH_BACK,
                        CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_LIST_FRONT, CMD_LIST_BACK,
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_LIST_BACK, CMD_POP_BACK,
                        CMD_PEEK_BACK};
      directed_vals = '{32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                        32'h0, 32'h0,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'h0, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'h0, 32'h0, 32'h0,
                        32'h0};
      foreach (directed_cmds[i]) send_request(directed_cmds[i], directed_vals[i]);

      // random phases; the first one fills the queue so full pushes show up early
      issued     = 0;
      burst_left = 0;
      mode       = PH_GROW;
      while (issued < RANDOM_ITEMS) begin
         phase_len = (issued == 0) ? 45 : $urandom_range(15, 50);
         for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               // some bursts follow back to back with no gap
               idle_cycles($urandom_range(3) == 0 ? 0 : $urandom_range(1, 5));
            end
            burst_left--;
            send_request(random_command(mode), random_value());
            issued++;
         end
         mode = phase_mode_type'($urandom_range(2));
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (book.awaited.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      book.check_drained();

      $display("run covered %0d requests and %0d checked results", book.requests, book.checked);
      $display("full pushes %0d, empty answers %0d, listed entries %0d",
               book.full_pushes, book.empty_answers, book.listed_entries);
      if (book.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
